// ----- rtl/mdag_pkg.sv -----
// ----------------------------------------------------------------------------
// mdag_pkg
// Shared types and constants of the row-major array address generator:
// item kinds, stream field positions and descriptor memory layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package mdag_pkg;

  // Descriptor table geometry.
  localparam int unsigned ARR_W       = 4;
  localparam int unsigned DIM_W       = 4;
  localparam int unsigned MAX_ARRAYS  = 1 << ARR_W;
  localparam int unsigned MAX_DIMS    = 1 << DIM_W;
  localparam int unsigned SLOT_W      = ARR_W + DIM_W;
  localparam int unsigned SLOT_COUNT  = MAX_ARRAYS * MAX_DIMS;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned ESIZE_W     = 31;
  localparam int unsigned DCOUNT_W    = 5;

  typedef logic [WORD_W-1:0] word_t;

  // Item kinds carried on in_tuser.
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_HEADER = 2'd0;
  localparam kind_t KIND_BOUNDS = 2'd1;
  localparam kind_t KIND_INDEX  = 2'd2;

  // Input tdata layout, lowest bit first.
  localparam int unsigned IN_ARR_LSB    = 0;
  localparam int unsigned IN_DIM_LSB    = IN_ARR_LSB + ARR_W;
  localparam int unsigned IN_LOWER_LSB  = IN_DIM_LSB + DIM_W;
  localparam int unsigned IN_UPPER_LSB  = IN_LOWER_LSB + WORD_W;
  localparam int unsigned IN_INDEX_LSB  = IN_UPPER_LSB + WORD_W;
  localparam int unsigned IN_BASE_LSB   = IN_INDEX_LSB + WORD_W;
  localparam int unsigned IN_ESIZE_LSB  = IN_BASE_LSB + WORD_W;
  localparam int unsigned IN_DCOUNT_LSB = IN_ESIZE_LSB + ESIZE_W;
  localparam int unsigned IN_USED_W     = IN_DCOUNT_LSB + DCOUNT_W;
  localparam int unsigned IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout.
  localparam int unsigned OUT_USED_W    = WORD_W + ARR_W;
  localparam int unsigned OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  // Header descriptor word: base, element size, dimension count.
  typedef struct packed {
    logic [DCOUNT_W-1:0] dim_count;
    logic [ESIZE_W-1:0]  elem_size;
    word_t               base;
  } desc_t;

  // Per-dimension word: extent and lower bound.
  typedef struct packed {
    word_t extent;
    word_t lower;
  } bound_t;

  localparam int unsigned DESC_W  = $bits(desc_t);
  localparam int unsigned BOUND_W = $bits(bound_t);

endpackage

`default_nettype wire

// ----- rtl/mdag_ram.sv -----
// ----------------------------------------------------------------------------
// mdag_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mdag_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/multidim_array_address_gen_unit.sv -----
// ----------------------------------------------------------------------------
// multidim_array_address_gen_unit
// Row-major element address generator over a table of array descriptors,
// with a bit-serial shift-and-add multiplier shared by both products.
// ----------------------------------------------------------------------------
//
//  Channel  Ports               Carries
//  -------  ------------------  ----------------------------------------------
//  input    in_tvalid/tready    kind on tuser, descriptor or index on tdata
//  output   out_tvalid/tready   element address and array id on tdata
//
//  Header and bound transactions write the descriptor memories and produce
//  no result. An index transaction reads its descriptor in the load state;
//  the multiplier then retires one multiplier bit per cycle to form the
//  offset, and on the array's last dimension goes on to form
//  base + element_size * offset.
//  Reset is synchronous and active low; descriptor memories are not cleared.
//  The output register lets the next transaction be taken while a result
//  waits; the multiplier holds its finished address until the register frees.
//
`default_nettype none

module multidim_array_address_gen_unit
  import mdag_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [1:0] kind
  input  wire logic [1:0]             in_tuser,
  // array_id, dim_number, lower_bound, upper_bound, index_value,
  // base_address, element_size, dimension_count, zero fill
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // element_address, result_array, zero fill
  output logic      [OUT_TDATA_W-1:0] out_tdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_MUL1 = 2'd2;
  localparam logic [1:0] ST_MUL2 = 2'd3;

  logic [1:0]        state_r, state_nxt;
  word_t             acc_r, acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  word_t             out_addr_r, out_addr_nxt;
  logic [ARR_W-1:0]  out_arr_r, out_arr_nxt;

  logic [ARR_W-1:0]  arr_r, arr_nxt;
  logic [DIM_W-1:0]  dim_r, dim_nxt;
  word_t             idx_r, idx_nxt;

  word_t             mcand_r, mcand_nxt;
  word_t             mplier_r, mplier_nxt;
  word_t             prod_r, prod_nxt;

  logic              in_fire;
  kind_t             in_kind;
  logic [ARR_W-1:0]  in_arr;
  logic [DIM_W-1:0]  in_dim;
  word_t             in_lower;
  word_t             in_upper;
  desc_t             in_desc;
  bound_t            in_bound;

  logic              desc_we, bound_we, rd_en;
  desc_t             desc_rd;
  bound_t            bound_rd;
  logic [BOUND_W-1:0] bound_rd_raw;
  logic [DESC_W-1:0]  desc_rd_raw;

  word_t             step_sum;
  logic              last_dim;

  assign in_kind  = in_tuser;
  assign in_arr   = in_tdata[IN_ARR_LSB +: ARR_W];
  assign in_dim   = in_tdata[IN_DIM_LSB +: DIM_W];
  assign in_lower = in_tdata[IN_LOWER_LSB +: WORD_W];
  assign in_upper = in_tdata[IN_UPPER_LSB +: WORD_W];

  assign in_desc.base      = in_tdata[IN_BASE_LSB +: WORD_W];
  assign in_desc.elem_size = in_tdata[IN_ESIZE_LSB +: ESIZE_W];
  assign in_desc.dim_count = in_tdata[IN_DCOUNT_LSB +: DCOUNT_W];
  assign in_bound.lower    = in_lower;
  assign in_bound.extent   = in_upper - in_lower + word_t'(1);

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign desc_we   = in_fire && (in_kind == KIND_HEADER);
  assign bound_we  = in_fire && (in_kind == KIND_BOUNDS);
  assign rd_en     = in_fire && (in_kind == KIND_INDEX);

  mdag_ram #(
    .WIDTH (DESC_W),
    .DEPTH (MAX_ARRAYS)
  ) u_desc_ram (
    .clk   (clk),
    .we    (desc_we),
    .waddr (in_arr),
    .wdata (in_desc),
    .re    (rd_en),
    .raddr (in_arr),
    .rdata (desc_rd_raw)
  );

  mdag_ram #(
    .WIDTH (BOUND_W),
    .DEPTH (SLOT_COUNT)
  ) u_bound_ram (
    .clk   (clk),
    .we    (bound_we),
    .waddr ({in_arr, in_dim}),
    .wdata (in_bound),
    .re    (rd_en),
    .raddr ({in_arr, in_dim}),
    .rdata (bound_rd_raw)
  );

  assign desc_rd  = desc_t'(desc_rd_raw);
  assign bound_rd = bound_t'(bound_rd_raw);

  // One multiplier bit per cycle: add the shifted multiplicand when set.
  assign step_sum = prod_r + (mplier_r[0] ? mcand_r : '0);

  assign last_dim = (desc_rd.dim_count != '0) &&
                    ({1'b0, dim_r} == (desc_rd.dim_count - DCOUNT_W'(1)));

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_addr_nxt  = out_addr_r;
    out_arr_nxt   = out_arr_r;
    arr_nxt       = arr_r;
    dim_nxt       = dim_r;
    idx_nxt       = idx_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    prod_nxt      = prod_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_kind)
            KIND_HEADER: acc_nxt = '0;
            KIND_INDEX: begin
              arr_nxt   = in_arr;
              dim_nxt   = in_dim;
              idx_nxt   = in_tdata[IN_INDEX_LSB +: WORD_W];
              state_nxt = ST_LOAD;
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        // Offset = prev * extent + (index - lower); start from the addend.
        mcand_nxt  = (dim_r == '0) ? '0 : acc_r;
        mplier_nxt = bound_rd.extent;
        prod_nxt   = idx_r - bound_rd.lower;
        state_nxt  = ST_MUL1;
      end
      ST_MUL1: begin
        if (mplier_r != '0) begin
          prod_nxt   = step_sum;
          mcand_nxt  = {mcand_r[WORD_W-2:0], 1'b0};
          mplier_nxt = {1'b0, mplier_r[WORD_W-1:1]};
        end else if (last_dim) begin
          acc_nxt    = '0;
          mcand_nxt  = prod_r;
          mplier_nxt = {1'b0, desc_rd.elem_size};
          prod_nxt   = desc_rd.base;
          state_nxt  = ST_MUL2;
        end else begin
          acc_nxt   = prod_r;
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL2: begin
        if (mplier_r != '0) begin
          prod_nxt   = step_sum;
          mcand_nxt  = {mcand_r[WORD_W-2:0], 1'b0};
          mplier_nxt = {1'b0, mplier_r[WORD_W-1:1]};
        end else if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = prod_r;
          out_arr_nxt   = arr_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_addr_r <= out_addr_nxt;
    out_arr_r  <= out_arr_nxt;
    arr_r      <= arr_nxt;
    dim_r      <= dim_nxt;
    idx_r      <= idx_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    prod_r     <= prod_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, out_arr_r, out_addr_r};

  // An accepted index transaction always starts the descriptor read phase.
  a_index_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_kind == KIND_INDEX) |=> (state_r == ST_LOAD))
    else $error("index transaction did not enter the load phase");

  // The load phase always hands over to the multiplier phase.
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |=> (state_r == ST_MUL1))
    else $error("load phase did not hand over to the multiplier");

  // A header transaction clears the running offset.
  a_header_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_kind == KIND_HEADER) |=> (acc_r == '0))
    else $error("header transaction left a stale offset");

  // A finished address is held while the output register is still full.
  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL2 && mplier_r == '0 && out_valid_r && !out_tready)
      |=> (state_r == ST_MUL2 && $stable(prod_r)))
    else $error("finished address dropped while output was full");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the row-major array address generator. A short
// table of directed transactions covers field extremes, every item kind and
// the accumulator corner cases. Random descriptor and index sequences follow,
// under several idle and stall patterns. Every result is compared in order
// with a prediction from the testbench's own copy of the descriptor tables,
// or with the address that a directed row gives.
// ----------------------------------------------------------------------------

module tb
  import mdag_pkg::*;
();

  localparam kind_t       KIND_UNUSED   = 2'd3;
  localparam int unsigned TOTAL_ITEMS   = 1350;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DRAIN_LIMIT   = 50000;
  localparam int unsigned TAIL_CYCLES   = 200;
  localparam int unsigned DIRECTED_ROWS = 26;
  localparam int unsigned RESULT_DEPTH  = 64;

  typedef struct packed {
    kind_t               kind;
    logic [ARR_W-1:0]    arr;
    logic [DIM_W-1:0]    dim;
    word_t               lower;
    word_t               upper;
    word_t               index;
    word_t               base;
    logic [ESIZE_W-1:0]  esize;
    logic [DCOUNT_W-1:0] dcount;
  } array_item_t;

  typedef struct packed {
    array_item_t item;
    logic        has_addr;
    word_t       addr;
  } directed_row_t;

  typedef struct packed {
    word_t            addr;
    logic [ARR_W-1:0] arr;
  } address_result_t;

  // Row layout: '{'{kind, array, dim, lower, upper, index, base, esize, dcount},
  //               typed result, typed address}
  localparam directed_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
    '{'{KIND_HEADER, 0, 0, 0, 0, 0, 'h1000, 4, 1}, 0, 0},
    '{'{KIND_BOUNDS, 0, 0, 0, 9, 0, 0, 0, 0}, 0, 0},
    '{'{KIND_INDEX, 0, 0, 0, 0, 3, 0, 0, 0}, 1, 'h100C},
    '{'{KIND_HEADER, 15, 0, 0, 0, 0, 'h7FFF_FFFF, 'h7FFF_FFFF, 2}, 0, 0},
    // Full signed range: the extent wraps to zero.
    '{'{KIND_BOUNDS, 15, 0, 'h8000_0000, 'h7FFF_FFFF, 0, 0, 0, 0}, 0, 0},
    '{'{KIND_BOUNDS, 15, 1, -5, 5, 0, 0, 0, 0}, 0, 0},
    '{'{KIND_INDEX, 15, 0, 0, 0, 'h7FFF_FFFF, 0, 0, 0}, 0, 0},
    '{'{KIND_INDEX, 15, 1, 0, 0, 'h8000_0000, 0, 0, 0}, 0, 0},
    // A second outermost index restarts the offset.
    '{'{KIND_INDEX, 15, 0, 0, 0, 0, 0, 0, 0}, 0, 0},
    '{'{KIND_INDEX, 15, 0, 0, 0, 1, 0, 0, 0}, 0, 0},
    '{'{KIND_INDEX, 15, 1, 0, 0, -5, 0, 0, 0}, 0, 0},
    // A dimension past the count accumulates silently.
    '{'{KIND_BOUNDS, 15, 3, 0, 0, 0, 0, 0, 0}, 0, 0},
    '{'{KIND_INDEX, 15, 3, 0, 0, 7, 0, 0, 0}, 0, 0},
    '{'{KIND_INDEX, 15, 1, 0, 0, 0, 0, 0, 0}, 0, 0},
    '{'{KIND_HEADER, 1, 0, 0, 0, 0, 0, 1, 3}, 0, 0},
    '{'{KIND_BOUNDS, 1, 0, 1, 4, 0, 0, 0, 0}, 0, 0},
    '{'{KIND_BOUNDS, 1, 1, 1, 4, 0, 0, 0, 0}, 0, 0},
    '{'{KIND_BOUNDS, 1, 2, 1, 4, 0, 0, 0, 0}, 0, 0},
    '{'{KIND_INDEX, 1, 0, 0, 0, 2, 0, 0, 0}, 0, 0},
    // A header in the middle of an index run clears the offset.
    '{'{KIND_HEADER, 2, 0, 0, 0, 0, 'hFFFF_FFFF, 0, 0}, 0, 0},
    '{'{KIND_INDEX, 1, 1, 0, 0, 3, 0, 0, 0}, 0, 0},
    '{'{KIND_INDEX, 1, 2, 0, 0, 4, 0, 0, 0}, 0, 0},
    // A dimension count of zero never yields an address.
    '{'{KIND_BOUNDS, 2, 0, 0, 0, 0, 0, 0, 0}, 0, 0},
    '{'{KIND_INDEX, 2, 0, 0, 0, 0, 0, 0, 0}, 0, 0},
    '{'{KIND_UNUSED, 0, 0, '1, '1, '1, '1, '1, '1}, 0, 0},
    '{'{KIND_INDEX, 0, 0, 0, 0, 9, 0, 0, 0}, 1, 'h1024}
  };

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [1:0]             in_tuser   = '0;  // [1:0] kind
  // array_id, dim_number, lower_bound, upper_bound, index_value,
  // base_address, element_size, dimension_count, zero fill
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // element_address, result_array, zero fill
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Descriptor tables as the block should hold them.
  word_t               mirror_base   [MAX_ARRAYS];
  logic [ESIZE_W-1:0]  mirror_esize  [MAX_ARRAYS];
  logic [DCOUNT_W-1:0] mirror_dcount [MAX_ARRAYS];
  word_t               mirror_lower  [SLOT_COUNT];
  word_t               mirror_extent [SLOT_COUNT];
  word_t               running_offset = '0;

  // Which entries the stimulus has written so far.
  bit header_written [MAX_ARRAYS];
  bit bound_written  [SLOT_COUNT];

  // Predicted results in order, as a ring with free-running counters.
  address_result_t result_fifo [RESULT_DEPTH];
  int result_wr      = 0;
  int result_rd      = 0;
  int mismatch_count = 0;
  int items_sent     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_token     = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  multidim_array_address_gen_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void record_result(input address_result_t res);
    result_fifo[result_wr % RESULT_DEPTH] = res;
    result_wr++;
  endfunction

  function automatic int pending_count();
    return result_wr - result_rd;
  endfunction

  function automatic void predict_address(input array_item_t it, output bit produced,
                                          output address_result_t res);
    logic [SLOT_W-1:0] slot;
    word_t             prev;
    word_t             off;
    slot     = {it.arr, it.dim};
    produced = 1'b0;
    res      = '0;
    case (it.kind)
      KIND_HEADER: begin
        mirror_base[it.arr]   = it.base;
        mirror_esize[it.arr]  = it.esize;
        mirror_dcount[it.arr] = it.dcount;
        running_offset        = '0;
      end
      KIND_BOUNDS: begin
        mirror_lower[slot]  = it.lower;
        mirror_extent[slot] = it.upper - it.lower + word_t'(1);
      end
      KIND_INDEX: begin
        prev = (it.dim == '0) ? '0 : running_offset;
        off  = prev * mirror_extent[slot] + (it.index - mirror_lower[slot]);
        if (mirror_dcount[it.arr] != '0 &&
            {1'b0, it.dim} == mirror_dcount[it.arr] - DCOUNT_W'(1)) begin
          res.addr       = mirror_base[it.arr] + {1'b0, mirror_esize[it.arr]} * off;
          res.arr        = it.arr;
          produced       = 1'b1;
          running_offset = '0;
        end else begin
          running_offset = off;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic array_item_t random_item();
    array_item_t it;
    it.kind   = kind_t'($urandom);
    it.arr    = ARR_W'($urandom);
    it.dim    = DIM_W'($urandom);
    it.lower  = $urandom;
    it.upper  = $urandom;
    it.index  = $urandom;
    it.base   = $urandom;
    it.esize  = ESIZE_W'($urandom);
    it.dcount = DCOUNT_W'($urandom);
    return it;
  endfunction

  // Offers one transaction, waits for it to be taken and records what it
  // should produce.
  task automatic send_item(input array_item_t it, input bit typed = 1'b0,
                           input word_t typed_addr = '0);
    logic [IN_TDATA_W-1:0] fields;
    bit                    produced;
    address_result_t       res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    fields = '0;
    fields[IN_ARR_LSB    +: ARR_W]    = it.arr;
    fields[IN_DIM_LSB    +: DIM_W]    = it.dim;
    fields[IN_LOWER_LSB  +: WORD_W]   = it.lower;
    fields[IN_UPPER_LSB  +: WORD_W]   = it.upper;
    fields[IN_INDEX_LSB  +: WORD_W]   = it.index;
    fields[IN_BASE_LSB   +: WORD_W]   = it.base;
    fields[IN_ESIZE_LSB  +: ESIZE_W]  = it.esize;
    fields[IN_DCOUNT_LSB +: DCOUNT_W] = it.dcount;
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= fields;
    do @(posedge clk); while (!in_tready);
    predict_address(it, produced, res);
    if (typed) begin
      record_result('{addr: typed_addr, arr: it.arr});
    end else if (produced) begin
      record_result(res);
    end
    if (it.kind == KIND_HEADER) header_written[it.arr] = 1'b1;
    if (it.kind == KIND_BOUNDS) bound_written[{it.arr, it.dim}] = 1'b1;
    if (it.kind != KIND_UNUSED) items_sent++;
  endtask

  // Stops offering and waits until every predicted address has come out, or until the drain limit runs out.
  task automatic wait_drained();
    int n;
    n = 0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
  endtask

  // Index items look up the descriptor, so it must exist first; the stimulus ensures it for unused items as well.
  task automatic ensure_slot_written(input logic [ARR_W-1:0] arr,
                                     input logic [DIM_W-1:0] dim);
    array_item_t it;
    if (!header_written[arr]) begin
      it        = random_item();
      it.kind   = KIND_HEADER;
      it.arr    = arr;
      it.dcount = DCOUNT_W'($urandom_range(1, 6));
      send_item(it);
    end
    if (!bound_written[{arr, dim}]) begin
      it      = random_item();
      it.kind = KIND_BOUNDS;
      it.arr  = arr;
      it.dim  = dim;
      send_item(it);
    end
  endtask

  // Header, all bounds, then complete index runs, mostly inside the bounds.
  task automatic run_array_sequence();
    array_item_t      it;
    logic [ARR_W-1:0] arr;
    int               dc;
    int               mode;
    int               accesses;
    word_t            seq_lower  [MAX_DIMS];
    word_t            seq_extent [MAX_DIMS];
    arr  = ARR_W'($urandom);
    mode = $urandom_range(99);
    dc   = (mode < 80) ? $urandom_range(1, 4) :
           (mode < 95) ? $urandom_range(5, 15) : MAX_DIMS;
    it        = random_item();
    it.kind   = KIND_HEADER;
    it.arr    = arr;
    it.dcount = DCOUNT_W'(dc);
    if ($urandom_range(3) != 0) it.esize = ESIZE_W'($urandom_range(1, 16));
    send_item(it);
    for (int d = 0; d < dc; d++) begin
      it      = random_item();
      it.kind = KIND_BOUNDS;
      it.arr  = arr;
      it.dim  = DIM_W'(d);
      if ($urandom_range(3) != 0) begin
        it.lower = $urandom_range(20) - 10;
        it.upper = it.lower + $urandom_range(7);
      end
      seq_lower[d]  = it.lower;
      seq_extent[d] = it.upper - it.lower + word_t'(1);
      send_item(it);
    end
    accesses = (dc > 4) ? $urandom_range(1, 2) : $urandom_range(1, 5);
    repeat (accesses) begin
      for (int d = 0; d < dc; d++) begin
        it      = random_item();
        it.kind = KIND_INDEX;
        it.arr  = arr;
        it.dim  = DIM_W'(d);
        if (seq_extent[d] != 0 && $urandom_range(7) != 0) begin
          it.index = seq_lower[d] + $urandom % seq_extent[d];
        end
        send_item(it);
      end
    end
  endtask

  // Index runs out of order, cut short or interrupted by another header.
  task automatic run_broken_sequence();
    array_item_t      it;
    logic [ARR_W-1:0] arr;
    logic [DIM_W-1:0] dim;
    arr = ARR_W'($urandom);
    repeat ($urandom_range(2, 8)) begin
      if ($urandom_range(9) == 0) begin
        it        = random_item();
        it.kind   = KIND_HEADER;
        it.dcount = DCOUNT_W'($urandom_range(1, 6));
        send_item(it);
      end else begin
        dim = ($urandom_range(3) == 0) ? DIM_W'($urandom) : DIM_W'($urandom_range(0, 4));
        ensure_slot_written(arr, dim);
        it      = random_item();
        it.kind = KIND_INDEX;
        it.arr  = arr;
        it.dim  = dim;
        send_item(it);
      end
    end
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    address_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_count() == 0) begin
        $error("unexpected result transaction: element_address %h result_array %0d",
               out_tdata[WORD_W-1:0], out_tdata[WORD_W +: ARR_W]);
        mismatch_count++;
      end else begin
        want = result_fifo[result_rd % RESULT_DEPTH];
        result_rd++;
        if (out_tdata[WORD_W-1:0] !== want.addr) begin
          $error("element_address: expected %h, actual %h", want.addr,
                 out_tdata[WORD_W-1:0]);
          mismatch_count++;
        end
        if (out_tdata[WORD_W +: ARR_W] !== want.arr) begin
          $error("result_array: expected %0d, actual %0d", want.arr,
                 out_tdata[WORD_W +: ARR_W]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    array_item_t it;
    int          phase;
    int          next_phase;
    int          pick;
    bit          hold_done;
    phase     = 0;
    hold_done = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_item(DIRECTED_TABLE[r].item, DIRECTED_TABLE[r].has_addr, DIRECTED_TABLE[r].addr);
    end
    wait_drained();

    while (items_sent < TOTAL_ITEMS) begin
      next_phase = items_sent * 4 / TOTAL_ITEMS;
      if (next_phase != phase) begin
        // Let the block run dry before the traffic pattern changes.
        wait_drained();
        phase = next_phase;
        case (phase)
          1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
          default: begin send_idle_pct = 9; recv_stall_pct = 9; end
        endcase
      end
      if (!hold_done && items_sent >= TOTAL_ITEMS / 8) begin
        // The output backs up while the input keeps offering.
        hold_token++;
        hold_done = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 65) begin
        run_array_sequence();
      end else if (pick < 85) begin
        run_broken_sequence();
      end else begin
        it = random_item();
        if (it.kind == KIND_INDEX || it.kind == KIND_UNUSED) begin
          ensure_slot_written(it.arr, it.dim);
        end
        send_item(it);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_count() != 0) begin
      $error("%0d expected results never arrived", pending_count());
    end
    if (mismatch_count == 0 && pending_count() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mdag_pkg.sv
rtl/mdag_ram.sv
rtl/multidim_array_address_gen_unit.sv
tb/sv/tb.sv
